>>> design/lsbp_pkg.sv
// Shared types and constants for the LSB-first bit packer.
package lsbp_pkg;

	localparam int unsigned VAL_W   = 64;
	localparam int unsigned WIDTH_W = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned ACC_W   = VAL_W + BYTE_W - 1;

	localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(VAL_W);
	localparam logic [CNT_W-1:0]   BYTE_CNT  = CNT_W'(BYTE_W);
	localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(ACC_W);

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic [VAL_W-1:0]   value;
		logic [WIDTH_W-1:0] width;
		logic               last;
	} item_t;

	// Status the back reports to the top level.
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
	} pack_status_t;

endpackage

>>> design/lsbp_front.sv
// Front part: accepts input beats, saturates the width and masks the value.
module lsbp_front (
	input  logic [lsbp_pkg::VAL_W-1:0]   value,
	input  logic                         last_value,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lsbp_pkg::WIDTH_W-1:0] width_cfg,
	input  logic                         q_full,
	output logic                         push,
	output lsbp_pkg::item_t              push_item
);

	logic [lsbp_pkg::WIDTH_W-1:0] w_sat;
	logic [lsbp_pkg::VAL_W-1:0]   mask;

	// Widths above the value size count as the full value.
	always_comb begin
		w_sat = (width_cfg > lsbp_pkg::MAX_WIDTH) ? lsbp_pkg::MAX_WIDTH : width_cfg;
		if (w_sat == lsbp_pkg::MAX_WIDTH) begin
			mask = '1;
		end else begin
			mask = (lsbp_pkg::VAL_W'(1) << w_sat[lsbp_pkg::WIDTH_W-2:0]) - lsbp_pkg::VAL_W'(1);
		end
	end

	// The front takes a beat whenever the queue has room.
	assign in_stall        = q_full;
	assign push            = in_valid && !q_full;
	assign push_item.value = value & mask;
	assign push_item.width = w_sat;
	assign push_item.last  = last_value;

endmodule

>>> design/lsbp_queue.sv
// Short queue of classified items between the front and the back.
module lsbp_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsbp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output lsbp_pkg::item_t q_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

	lsbp_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full    = (fill_q == FULL_FILL);
	assign q_valid = (fill_q != '0);
	assign q_item  = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> design/lsbp_back.sv
// Back part: merges items with the leftover bits and emits one byte per beat.
module lsbp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  lsbp_pkg::item_t             q_item,
	output logic                        pop,
	output logic [lsbp_pkg::BYTE_W-1:0] packed_byte,
	output logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lsbp_pkg::pack_status_t      status
);

	logic [lsbp_pkg::ACC_W-1:0]  acc_q;
	logic [lsbp_pkg::CNT_W-1:0]  cnt_q;
	logic                        last_q;
	logic [lsbp_pkg::BYTE_W-1:0] byte_q;
	logic                        lastb_q;
	logic                        out_valid_q;

	logic emit_full;
	logic emit_flush;
	logic out_ready;
	logic do_emit;
	logic idle;
	logic [lsbp_pkg::ACC_W-1:0] acc_load;
	logic [lsbp_pkg::CNT_W-1:0] cnt_load;

	// A full byte goes out while at least eight bits wait; a last item flushes its partial byte.
	always_comb begin
		emit_full  = (cnt_q >= lsbp_pkg::BYTE_CNT);
		emit_flush = !emit_full && last_q && (cnt_q != '0);
		out_ready  = !out_valid_q || !out_stall;
		do_emit    = (emit_full || emit_flush) && out_ready;
		idle       = !emit_full && !emit_flush;
		pop        = idle && q_valid;
		acc_load   = lsbp_pkg::ACC_W'(acc_q[lsbp_pkg::BYTE_W-2:0])
		           | (lsbp_pkg::ACC_W'(q_item.value) << cnt_q[2:0]);
		cnt_load   = lsbp_pkg::CNT_W'(cnt_q[2:0]) + lsbp_pkg::CNT_W'(q_item.width);
	end

	// Accumulator and bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (do_emit) begin
			if (emit_full) begin
				acc_q <= acc_q >> lsbp_pkg::BYTE_W;
				cnt_q <= cnt_q - lsbp_pkg::BYTE_CNT;
			end else begin
				acc_q  <= '0;
				cnt_q  <= '0;
				last_q <= 1'b0;
			end
		end else if (pop) begin
			acc_q  <= acc_load;
			cnt_q  <= cnt_load;
			last_q <= q_item.last;
		end else if (idle) begin
			last_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			byte_q  <= acc_q[lsbp_pkg::BYTE_W-1:0];
			lastb_q <= emit_flush || (last_q && (cnt_q == lsbp_pkg::BYTE_CNT));
		end
	end

	assign packed_byte = byte_q;
	assign last_byte   = lastb_q;
	assign out_valid   = out_valid_q;
	assign status.cnt  = cnt_q;

endmodule

>>> design/lsb_first_bit_packer_unit.sv
// Top level of the LSB-first variable-width bit packer.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------
//  input   | in        | in_valid / in_stall | value[63:0], last_value
//  output  | out       | out_valid/out_stall | packed_byte[7:0], last_byte
//  config  | in        | cfg_we              | cfg_data[6:0] (value_width)
//
// An item of width W joined to C leftover bits is first loaded into the packing
// accumulator, which then gives one output byte per cycle while out_stall is low:
// floor((C+W)/8) bytes, plus one flush byte when a last item leaves a partial byte.
// The back takes no new item from the queue until those bytes have gone out.
// Reset clears the leftover bits, the queue and the output valid flag, and sets
// value_width to 64. The front keeps accepting beats until the queue is full, while
// the back drains; an output stall on a valid byte holds the byte register and
// stops further bytes.
module lsb_first_bit_packer_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lsbp_pkg::WIDTH_W-1:0] cfg_data,
	input  logic [lsbp_pkg::VAL_W-1:0]   value,
	input  logic                         last_value,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic [lsbp_pkg::BYTE_W-1:0]  packed_byte,
	output logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall
);

	logic [lsbp_pkg::WIDTH_W-1:0] width_q;
	logic                         q_full;
	logic                         push;
	lsbp_pkg::item_t              push_item;
	logic                         pop;
	logic                         q_valid;
	lsbp_pkg::item_t              q_item;
	lsbp_pkg::pack_status_t       status;

	// Width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= lsbp_pkg::MAX_WIDTH;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	lsbp_front u_front (
		.value      (value),
		.last_value (last_value),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.width_cfg  (width_q),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	lsbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	lsbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (pop),
		.packed_byte (packed_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status)
	);

	// The back never takes an item from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("item taken from an empty queue");

	// An accepted input beat is waiting in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> q_valid)
		else $error("accepted beat did not reach the queue");

	// The accumulator never holds more bits than leftover plus one value.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.cnt <= lsbp_pkg::MAX_CNT)
		else $error("packing accumulator overflow");

endmodule

>>> sim/lsb_first_bit_packer_unit_test.sv
// Self-checking testbench for the LSB-first variable-width bit packer unit.
`timescale 1ns / 100ps

module lsb_first_bit_packer_unit_test;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_ITEMS  = 135;
	localparam int NO_WRITE      = -1;

	// One output beat: the packed byte and its end-of-stream mark.
	typedef struct {
		logic [lsbp_pkg::BYTE_W-1:0] data;
		logic                        fin;
	} packed_beat_t;

	// One row of the directed stimulus table.
	typedef struct {
		int                         width;
		logic [lsbp_pkg::VAL_W-1:0] val;
		logic                       fin;
		bit                         typed;
		int                         n_bytes;
		logic [71:0]                bytes;
		bit                         marked;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lsbp_pkg::WIDTH_W-1:0]   cfg_data;
	logic [lsbp_pkg::VAL_W-1:0]     value;
	logic                           last_value;
	logic                           in_valid;
	logic                           in_stall;
	logic [lsbp_pkg::BYTE_W-1:0]    packed_byte;
	logic                           last_byte;
	logic                           out_valid;
	logic                           out_stall;

	lsb_first_bit_packer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.value       (value),
		.last_value  (last_value),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.packed_byte (packed_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

	// Predictor state: configured width and the bits still waiting for a byte.
	logic [lsbp_pkg::WIDTH_W-1:0] width_reg;
	logic [6:0]                   pend_bits;
	int                           pend_cnt;
	packed_beat_t                 step_beats [0:8];

	packed_beat_t expected_bytes [$];
	stim_row_t    stim_table [$];

	int mismatches;
	int items_sent;
	int bytes_checked;
	int width_writes;
	int cycles;
	int burst_left;
	int stall_mode;
	int mode_left;
	int run_left;

	// Clock generation.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Packs one value into the predictor state; returns the number of bytes it completes.
	function automatic int pack_value(input logic [lsbp_pkg::VAL_W-1:0] v, input logic fin);
		logic [127:0]               acc;
		logic [lsbp_pkg::VAL_W-1:0] kept;
		int                         w;
		int                         total;
		int                         n;
		w = (width_reg > lsbp_pkg::MAX_WIDTH) ? int'(lsbp_pkg::VAL_W) : int'(width_reg);
		if (w == 0)
			kept = '0;
		else if (w < int'(lsbp_pkg::VAL_W))
			kept = v & ((64'd1 << w) - 64'd1);
		else
			kept = v;
		acc = ({64'd0, kept} << pend_cnt) | {121'd0, pend_bits};
		total = pend_cnt + w;
		n = 0;
		while (total >= 8) begin
			step_beats[n].data = acc[7:0];
			step_beats[n].fin = 1'b0;
			acc = acc >> 8;
			total -= 8;
			n++;
		end
		if (fin) begin
			// A last value flushes the partial byte, or marks the final full byte.
			if (total > 0) begin
				step_beats[n].data = acc[7:0];
				step_beats[n].fin = 1'b1;
				n++;
			end else if (n > 0) begin
				step_beats[n-1].fin = 1'b1;
			end
			pend_bits = '0;
			pend_cnt = 0;
		end else begin
			pend_bits = acc[6:0];
			pend_cnt = total;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic add_row(input int width, input logic [lsbp_pkg::VAL_W-1:0] val,
			input int fin, input int typed, input int n_bytes, input logic [71:0] bytes,
			input int marked);
		stim_row_t row;
		row.width = width;
		row.val = val;
		row.fin = (fin != 0);
		row.typed = (typed != 0);
		row.n_bytes = n_bytes;
		row.bytes = bytes;
		row.marked = (marked != 0);
		stim_table.push_back(row);
	endtask

	// Writes the width register once the block has drained.
	task automatic write_width(input logic [lsbp_pkg::WIDTH_W-1:0] w);
		in_valid <= 1'b0;
		wait (expected_bytes.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
		width_writes++;
	endtask

	// Presents one beat, in bursts with random gaps, and returns once it is taken.
	task automatic send_value(input logic [lsbp_pkg::VAL_W-1:0] v, input logic fin);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		value <= v;
		last_value <= fin;
		do
			@(posedge clk);
		while (in_stall);
		burst_left--;
		items_sent++;
	endtask

	// Predicts the bytes of one value, queues them and sends the value.
	task automatic run_value(input logic [lsbp_pkg::VAL_W-1:0] v, input logic fin);
		int n;
		n = pack_value(v, fin);
		for (int i = 0; i < n; i++)
			expected_bytes.push_back(step_beats[i]);
		send_value(v, fin);
	endtask

	// Receiver stall pattern: free running, coin flips, or runs of stall and no stall.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (run_left == 0) begin
					out_stall <= !out_stall;
					run_left <= $urandom_range(1, 8);
				end else begin
					run_left <= run_left - 1;
				end
			end
		endcase
	end

	// Compares every accepted output beat with the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					packed_byte, last_byte));
			end else begin
				packed_beat_t exp_beat;
				exp_beat = expected_bytes.pop_front();
				bytes_checked++;
				if (packed_byte !== exp_beat.data)
					report_mismatch($sformatf("packed_byte %02h, expected %02h",
						packed_byte, exp_beat.data));
				if (last_byte !== exp_beat.fin)
					report_mismatch($sformatf("last_byte %0b, expected %0b",
						last_byte, exp_beat.fin));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding", cycles,
				expected_bytes.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		stim_row_t                  row;
		logic [lsbp_pkg::VAL_W-1:0] v;
		logic                       fin;
		int                         seg_len;
		int                         pick;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		value = '0;
		last_value = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		width_reg = lsbp_pkg::MAX_WIDTH;
		pend_bits = '0;
		pend_cnt = 0;
		mismatches = 0;
		items_sent = 0;
		bytes_checked = 0;
		width_writes = 0;
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		mode_left = 0;
		run_left = 0;

		// Directed table. Reset width is 64, so the first rows need no write.
		add_row(NO_WRITE, 64'h0123_4567_89AB_CDEF, 1, 1, 8, {8'h00, 64'h0123_4567_89AB_CDEF}, 1);
		add_row(NO_WRITE, '1, 1, 1, 8, {8'h00, 64'hFFFF_FFFF_FFFF_FFFF}, 1);
		add_row(NO_WRITE, '0, 0, 1, 8, 72'h0, 0);
		// Bits above the width are dropped.
		add_row(8, 64'hFFFF_FFFF_FFFF_FFA5, 1, 1, 1, 72'hA5, 1);
		add_row(1, 64'h1, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h1, 1, 0, 0, 72'h0, 0);
		// Width zero adds nothing; a last value on an empty state yields no byte.
		add_row(0, '1, 0, 1, 0, 72'h0, 0);
		add_row(NO_WRITE, '1, 1, 1, 0, 72'h0, 0);
		// Width zero with pending bits only flushes them.
		add_row(3, 64'h5, 0, 1, 0, 72'h0, 0);
		add_row(0, 64'hFF, 1, 1, 1, 72'h05, 1);
		// Two nibbles fill one byte exactly, so the full byte carries the mark.
		add_row(4, 64'hA, 0, 1, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h5, 1, 1, 1, 72'h5A, 1);
		// Widths above 64 saturate.
		add_row(127, 64'hDEAD_BEEF_CAFE_F00D, 0, 0, 0, 72'h0, 0);
		add_row(7, 64'h55, 0, 0, 0, 72'h0, 0);
		add_row(65, 64'h8000_0000_0000_0001, 1, 0, 0, 72'h0, 0);
		add_row(63, '1, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h1234_5678_9ABC_DEF0, 1, 0, 0, 72'h0, 0);
		add_row(9, 64'h1FF, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h0, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h155, 1, 0, 0, 72'h0, 0);
		add_row(2, 64'h3, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h0, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h3, 0, 0, 0, 72'h0, 0);
		add_row(NO_WRITE, 64'h0, 1, 0, 0, 72'h0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: typed rows queue their bytes from the table.
		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.width != NO_WRITE)
				write_width(row.width[lsbp_pkg::WIDTH_W-1:0]);
			if (row.typed) begin
				void'(pack_value(row.val, row.fin));
				for (int k = 0; k < row.n_bytes; k++) begin
					packed_beat_t beat;
					beat.data = row.bytes[8*k +: 8];
					beat.fin = row.marked && (k == row.n_bytes - 1);
					expected_bytes.push_back(beat);
				end
				send_value(row.val, row.fin);
			end else begin
				run_value(row.val, row.fin);
			end
		end

		// Random part: streams of random length under a random width.
		while (items_sent < RANDOM_ITEMS + stim_table.size()) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_width('0);
				1: write_width(lsbp_pkg::WIDTH_W'($urandom_range(65, 127)));
				2: write_width(lsbp_pkg::MAX_WIDTH);
				3: write_width(lsbp_pkg::WIDTH_W'(1));
				default: write_width(lsbp_pkg::WIDTH_W'($urandom_range(1, 63)));
			endcase
			seg_len = (width_reg == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
			for (int i = 0; i < seg_len; i++) begin
				case ($urandom_range(0, 9))
					0: v = '0;
					1: v = '1;
					default: v = {$urandom, $urandom};
				endcase
				if (i == seg_len - 1)
					fin = ($urandom_range(0, 4) != 0);
				else
					fin = ($urandom_range(0, 19) == 0);
				run_value(v, fin);
			end
		end

		// Drain and let the block settle before the verdict.
		in_valid <= 1'b0;
		wait (expected_bytes.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never arrived",
				expected_bytes.size()));

		$display("Packed %0d values into %0d checked bytes under %0d width settings,",
			items_sent, bytes_checked, width_writes);
		$display("including widths 0, 1, 64 and saturated widths above 64.");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/lsbp_pkg.sv
design/lsbp_front.sv
design/lsbp_queue.sv
design/lsbp_back.sv
design/lsb_first_bit_packer_unit.sv
sim/lsb_first_bit_packer_unit_test.sv
